// ===== sv/bcm_pkg.sv =====
// Shared constants, types and helpers for the BCM shift register LED driver.
// No dependencies; the files that use it refer to it by scoped names.
package bcm_pkg;

  localparam int MaxRegs    = 8;
  localparam int MaxWidth   = 32;
  localparam int MaxDepth   = 12;
  localparam int MinWidth   = 4;
  localparam int MinDepth   = 4;
  localparam int StoreDepth = 256;

  localparam int AddrW    = $clog2(StoreDepth);
  localparam int DutyW    = MaxDepth;
  localparam int LaneW    = $clog2(MaxRegs);
  localparam int CountW   = 4;
  localparam int WidthW   = 6;
  localparam int DepthW   = 4;
  localparam int LatchW   = 5;
  localparam int PosW     = 5;
  localparam int RepW     = 11;
  localparam int SpanW    = RepW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 6;
  localparam int ChainW   = CountW + WidthW;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_REG_COUNT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REG_WIDTH     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_DEPTH     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LATCH_POS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REVERSE_ORDER = 3'd4;

  typedef struct packed {
    logic [CountW-1:0] reg_count;
    logic [WidthW-1:0] reg_width;
    logic [DepthW-1:0] bit_depth;
    logic [LatchW-1:0] latch_pos;
    logic              reverse_order;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reg_count:     CountW'(8),
    reg_width:     WidthW'(8),
    bit_depth:     DepthW'(8),
    latch_pos:     LatchW'(7),
    reverse_order: 1'b0
  };

  // Geometry after saturation to the legal ranges.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [WidthW-1:0] width;
    logic [DepthW-1:0] depth;
    logic [LatchW-1:0] lpos;
    logic              reverse;
  } geom_t;

  // Frame counter control and status.
  typedef struct packed {
    logic cfg_restart;
    logic start;
    logic advance;
  } ctr_ctl_t;

  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [DepthW-1:0] plane;
    logic              last;
  } ctr_stat_t;

  // Lane gather control and status.
  typedef struct packed {
    logic load;
    logic issue;
  } gth_ctl_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             lane_last;
  } gth_stat_t;

  function automatic geom_t geom_of(input cfg_t c);
    geom_t g;
    g.count = (c.reg_count == '0) ? CountW'(1) :
              (c.reg_count > CountW'(MaxRegs)) ? CountW'(MaxRegs) : c.reg_count;
    g.width = (c.reg_width < WidthW'(MinWidth)) ? WidthW'(MinWidth) :
              (c.reg_width > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : c.reg_width;
    g.depth = (c.bit_depth < DepthW'(MinDepth)) ? DepthW'(MinDepth) :
              (c.bit_depth > DepthW'(MaxDepth)) ? DepthW'(MaxDepth) : c.bit_depth;
    g.lpos  = ({1'b0, c.latch_pos} > (g.width - WidthW'(1))) ?
              LatchW'(g.width - WidthW'(1)) : c.latch_pos;
    g.reverse = c.reverse_order;
    return g;
  endfunction

endpackage

// ===== sv/bcm_if.sv =====
// Handshake channels of the BCM LED driver: input items and output words.
// Depends on bcm_pkg for field widths.
interface bcm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [bcm_pkg::AddrW-1:0]      led_index;
  logic [bcm_pkg::DutyW-1:0]      duty_value;

  modport source(output valid, op, led_index, duty_value, input ready);
  modport sink(input valid, op, led_index, duty_value, output ready);
endinterface

interface bcm_out_if;
  logic                           valid;
  logic                           ready;
  logic [bcm_pkg::MaxRegs-1:0]    data_lines;
  logic                           latch_line;
  logic                           period_end;

  modport source(output valid, data_lines, latch_line, period_end, input ready);
  modport sink(input valid, data_lines, latch_line, period_end, output ready);
endinterface

// ===== sv/bcm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bcm_ram #(
  parameter int Width = 12,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bcm_frame_ctr.sv =====
// Modulation frame counters: shift position, repeat and bit plane.
// Depends on bcm_pkg.
module bcm_frame_ctr (
  input  logic              clk,
  input  logic              rst_n,
  input  bcm_pkg::geom_t    geom,
  input  bcm_pkg::ctr_ctl_t ctl,
  output bcm_pkg::ctr_stat_t stat
);

  logic [bcm_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [bcm_pkg::DepthW-1:0] plane_r, plane_nxt;
  logic [bcm_pkg::RepW-1:0]   rep_r, rep_nxt;

  logic [bcm_pkg::SpanW-1:0]  span;
  logic [bcm_pkg::WidthW-1:0] pos_inc;
  logic [bcm_pkg::SpanW-1:0]  rep_inc;
  logic [bcm_pkg::DepthW-1:0] plane_inc;
  logic                       oob;

  always_comb begin
    span      = bcm_pkg::SpanW'(1) << plane_r;
    oob       = (plane_r >= geom.depth) || ({1'b0, pos_r} >= geom.width) ||
                ({1'b0, rep_r} >= span);
    pos_inc   = {1'b0, pos_r} + bcm_pkg::WidthW'(1);
    rep_inc   = {1'b0, rep_r} + bcm_pkg::SpanW'(1);
    plane_inc = plane_r + bcm_pkg::DepthW'(1);

    pos_nxt   = pos_r;
    rep_nxt   = rep_r;
    plane_nxt = plane_r;
    if (ctl.cfg_restart || (ctl.start && oob)) begin
      pos_nxt   = '0;
      rep_nxt   = '0;
      plane_nxt = '0;
    end else if (ctl.advance) begin
      if (pos_inc >= geom.width) begin
        pos_nxt = '0;
        if (rep_inc >= span) begin
          rep_nxt   = '0;
          plane_nxt = (plane_inc >= geom.depth) ? '0 : plane_inc;
        end else begin
          rep_nxt = bcm_pkg::RepW'(rep_inc);
        end
      end else begin
        pos_nxt = bcm_pkg::PosW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      rep_r   <= '0;
      plane_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      rep_r   <= rep_nxt;
      plane_r <= plane_nxt;
    end
  end

  assign stat.pos   = pos_r;
  assign stat.plane = plane_r;
  assign stat.last  = (plane_r == geom.depth - bcm_pkg::DepthW'(1)) &&
                      ({1'b0, rep_r} == span - bcm_pkg::SpanW'(1)) &&
                      ({1'b0, pos_r} == geom.width - bcm_pkg::WidthW'(1));

endmodule

// ===== sv/bcm_lane_gather.sv =====
// Walks the displayed store once per lane and collects one plane bit per chain.
// Depends on bcm_pkg; drives the read port of the displayed-store RAM.
module bcm_lane_gather (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcm_pkg::geom_t               geom,
  input  bcm_pkg::ctr_stat_t           ctr,
  input  bcm_pkg::gth_ctl_t            ctl,
  input  logic [bcm_pkg::DutyW-1:0]    rd_data,
  output bcm_pkg::gth_stat_t           stat,
  output logic [bcm_pkg::MaxRegs-1:0]  data_lines
);

  logic [bcm_pkg::AddrW-1:0]   addr_r;
  logic [bcm_pkg::LaneW-1:0]   lane_r;
  logic [bcm_pkg::LaneW-1:0]   lane_d_r;
  logic                        vld_r;
  logic [bcm_pkg::MaxRegs-1:0] acc_r;
  logic [bcm_pkg::AddrW-1:0]   led_pos;

  assign led_pos = geom.reverse ? bcm_pkg::AddrW'(ctr.pos) :
                   bcm_pkg::AddrW'(geom.width - bcm_pkg::WidthW'(1) -
                                   bcm_pkg::WidthW'(ctr.pos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.issue;
    end
  end

  // Address advances by one chain width per lane; wraps at the store depth.
  always_ff @(posedge clk) begin
    lane_d_r <= lane_r;
    if (ctl.load) begin
      addr_r <= led_pos;
      lane_r <= '0;
      acc_r  <= '0;
    end else begin
      if (ctl.issue) begin
        addr_r <= addr_r + bcm_pkg::AddrW'(geom.width);
        lane_r <= lane_r + bcm_pkg::LaneW'(1);
      end
      if (vld_r) begin
        acc_r[lane_d_r] <= rd_data[ctr.plane];
      end
    end
  end

  assign stat.rd_en     = ctl.issue;
  assign stat.rd_addr   = addr_r;
  assign stat.lane_last = ({1'b0, lane_r} == geom.count - bcm_pkg::CountW'(1));
  assign data_lines     = acc_r;

endmodule

// ===== sv/bcm_shift_register_led_driver.sv =====
// BCM driver for up to eight chained shift registers; top level.
// A write item is taken in the idle state. A tick steps through the load, read,
// drain and emit states to its output word, one display-store read per chain
// through the single read port. After the last word of a period with pending
// writes, a copy of all 256 entries into the display store runs with the input
// held off. After reset a clearing pass zeroes both stores before the first transfer.
module bcm_shift_register_led_driver (
  input  logic                          clk,
  input  logic                          rst_n,
  bcm_in_if.sink                        in_if,
  bcm_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [bcm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bcm_pkg::CfgDataW-1:0]  cfg_wdata
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_COPY  = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  bcm_pkg::cfg_t               cfg_r;
  bcm_pkg::geom_t              geom;
  logic [bcm_pkg::AddrW-1:0]   cnt_r, cnt_nxt;
  logic                        pending_r, pending_nxt;
  logic                        cp_vld_r;
  logic [bcm_pkg::AddrW-1:0]   cp_addr_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [bcm_pkg::MaxRegs-1:0] out_data_r;
  logic                        out_latch_r;
  logic                        out_end_r;

  logic                        in_fire, wr_item, tick_item, wr_ok, emit_fire, cfg_restart;
  logic [bcm_pkg::ChainW-1:0]  chain_len;
  logic [bcm_pkg::DutyW-1:0]   duty_mask;

  bcm_pkg::ctr_ctl_t           ctr_ctl;
  bcm_pkg::ctr_stat_t          ctr_stat;
  bcm_pkg::gth_ctl_t           gth_ctl;
  bcm_pkg::gth_stat_t          gth_stat;
  logic [bcm_pkg::MaxRegs-1:0] gth_data;

  logic                        led_we, led_re;
  logic [bcm_pkg::AddrW-1:0]   led_waddr;
  logic [bcm_pkg::DutyW-1:0]   led_wdata, led_rdata;
  logic                        shown_we;
  logic [bcm_pkg::AddrW-1:0]   shown_waddr;
  logic [bcm_pkg::DutyW-1:0]   shown_wdata, shown_rdata;

  assign geom = bcm_pkg::geom_of(cfg_r);

  // Configuration registers
  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_we && (cfg_index inside {[bcm_pkg::CFG_REG_COUNT:bcm_pkg::CFG_REVERSE_ORDER]})) begin
      cfg_restart = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bcm_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bcm_pkg::CFG_REG_COUNT:     cfg_r.reg_count     <= cfg_wdata[bcm_pkg::CountW-1:0];
        bcm_pkg::CFG_REG_WIDTH:     cfg_r.reg_width     <= cfg_wdata[bcm_pkg::WidthW-1:0];
        bcm_pkg::CFG_BIT_DEPTH:     cfg_r.bit_depth     <= cfg_wdata[bcm_pkg::DepthW-1:0];
        bcm_pkg::CFG_LATCH_POS:     cfg_r.latch_pos     <= cfg_wdata[bcm_pkg::LatchW-1:0];
        bcm_pkg::CFG_REVERSE_ORDER: cfg_r.reverse_order <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input decode
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign wr_item     = in_fire && (in_if.op == bcm_pkg::OP_WRITE);
  assign tick_item   = in_fire && (in_if.op == bcm_pkg::OP_TICK);
  assign chain_len   = bcm_pkg::ChainW'(geom.count) * bcm_pkg::ChainW'(geom.width);
  assign wr_ok       = wr_item && (bcm_pkg::ChainW'(in_if.led_index) < chain_len);
  assign duty_mask   = ~({bcm_pkg::DutyW{1'b1}} << geom.depth);
  assign emit_fire   = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pending_nxt = pending_r;
    gth_ctl     = '0;
    led_re      = 1'b0;
    if (wr_ok) begin
      pending_nxt = 1'b1;
    end
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + bcm_pkg::AddrW'(1);
        if (cnt_r == bcm_pkg::AddrW'(bcm_pkg::StoreDepth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick_item) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        gth_ctl.load = 1'b1;
        state_nxt    = ST_READ;
      end
      ST_READ: begin
        gth_ctl.issue = 1'b1;
        if (gth_stat.lane_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          if (ctr_stat.last && pending_r) begin
            state_nxt   = ST_COPY;
            cnt_nxt     = '0;
            pending_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COPY: begin
        led_re  = 1'b1;
        cnt_nxt = cnt_r + bcm_pkg::AddrW'(1);
        if (cnt_r == bcm_pkg::AddrW'(bcm_pkg::StoreDepth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      pending_r <= 1'b0;
      cp_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pending_r <= pending_nxt;
      cp_vld_r  <= led_re;
    end
  end

  // Copy write trails its read, landing in the cycle after it
  always_ff @(posedge clk) begin
    cp_addr_r <= cnt_r;
  end

  // Pending-write store
  assign led_we    = (state_r == ST_CLEAR) || wr_ok;
  assign led_waddr = (state_r == ST_CLEAR) ? cnt_r : in_if.led_index;
  assign led_wdata = (state_r == ST_CLEAR) ? '0 : (in_if.duty_value & duty_mask);

  bcm_ram #(
    .Width(bcm_pkg::DutyW),
    .Depth(bcm_pkg::StoreDepth)
  ) u_led_ram (
    .clk   (clk),
    .we    (led_we),
    .waddr (led_waddr),
    .wdata (led_wdata),
    .re    (led_re),
    .raddr (cnt_r),
    .rdata (led_rdata)
  );

  // Displayed store
  assign shown_we    = (state_r == ST_CLEAR) || cp_vld_r;
  assign shown_waddr = (state_r == ST_CLEAR) ? cnt_r : cp_addr_r;
  assign shown_wdata = (state_r == ST_CLEAR) ? '0 : led_rdata;

  bcm_ram #(
    .Width(bcm_pkg::DutyW),
    .Depth(bcm_pkg::StoreDepth)
  ) u_shown_ram (
    .clk   (clk),
    .we    (shown_we),
    .waddr (shown_waddr),
    .wdata (shown_wdata),
    .re    (gth_stat.rd_en),
    .raddr (gth_stat.rd_addr),
    .rdata (shown_rdata)
  );

  assign ctr_ctl.cfg_restart = cfg_restart;
  assign ctr_ctl.start       = tick_item;
  assign ctr_ctl.advance     = emit_fire;

  bcm_frame_ctr u_frame_ctr (
    .clk   (clk),
    .rst_n (rst_n),
    .geom  (geom),
    .ctl   (ctr_ctl),
    .stat  (ctr_stat)
  );

  bcm_lane_gather u_lane_gather (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .ctr        (ctr_stat),
    .ctl        (gth_ctl),
    .rd_data    (shown_rdata),
    .stat       (gth_stat),
    .data_lines (gth_data)
  );

  // Output register; hold the word until the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r  <= gth_data;
      out_latch_r <= (ctr_stat.pos == geom.lpos);
      out_end_r   <= ctr_stat.last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.data_lines = out_data_r;
  assign out_if.latch_line = out_latch_r;
  assign out_if.period_end = out_end_r;

endmodule

// ===== sim/bcm_shift_register_led_driver_test.sv =====
// Self-checking bench for the BCM shift register LED driver: directed table, then random phases.
// Depends on bcm_pkg and the channel interfaces in bcm_if.sv; the scan predictor lives here.
module bcm_shift_register_led_driver_test;

  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 14;
  localparam int MAX_REPORTS    = 10;

  localparam logic [bcm_pkg::CfgIdxW-1:0] CFG_SPARE = 3'd5;

  typedef struct packed {
    logic [bcm_pkg::MaxRegs-1:0] data;
    logic                        latch;
    logic                        last;
  } word_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [bcm_pkg::CfgIdxW-1:0]  reg_idx;
    logic [bcm_pkg::CfgDataW-1:0] reg_val;
    logic                         op;
    logic [bcm_pkg::AddrW-1:0]    led;
    logic [bcm_pkg::DutyW-1:0]    duty;
    logic                         typed;
    word_t                        want;
  } row_t;

  localparam row_t PLAN [30] = '{
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd0, 12'h000, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd0, 12'hfff, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd63, 12'h000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd64, 12'hfff, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd0, 12'h000, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_CFG, bcm_pkg::CFG_REG_COUNT, 6'd0, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_REG_WIDTH, 6'd63, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_BIT_DEPTH, 6'd15, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_LATCH_POS, 6'd31, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_REVERSE_ORDER, 6'd1, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd255, 12'hfff, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd32, 12'hfff, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd255, 12'hfff, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd31, 12'habc, 1'b0, '0},
    '{ROW_CFG, CFG_SPARE, 6'd63, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd0, 12'h000, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_REG_COUNT, 6'd15, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_REG_WIDTH, 6'd0, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_BIT_DEPTH, 6'd0, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_LATCH_POS, 6'd31, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_REVERSE_ORDER, 6'd0, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd31, 12'hfff, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_WRITE, 8'd32, 12'hfff, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd0, 12'h000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd1, 12'h001, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd2, 12'h002, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd3, 12'h003, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd4, 12'h004, 1'b0, '0},
    '{ROW_CFG, bcm_pkg::CFG_LATCH_POS, 6'd0, bcm_pkg::OP_WRITE, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, bcm_pkg::OP_TICK, 8'd0, 12'h000, 1'b1, '{8'h00, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [bcm_pkg::CfgIdxW-1:0] cfg_index;
  logic [bcm_pkg::CfgDataW-1:0] cfg_wdata;

  bcm_in_if  in_ch();
  bcm_out_if out_ch();

  bcm_shift_register_led_driver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Scan predictor state
  bcm_pkg::cfg_t             shadow_cfg;
  logic [bcm_pkg::DutyW-1:0] duty_ram  [bcm_pkg::StoreDepth];
  logic [bcm_pkg::DutyW-1:0] shown_ram [bcm_pkg::StoreDepth];
  logic                      refresh_due;
  int                        plane;
  int                        reps;
  int                        slot;

  word_t words_due [$];
  word_t want_word;
  bit    steady;
  int    errors;
  int    idle_cycles;
  int    n_ticks;
  int    n_writes;
  int    n_reg_writes;
  int    n_checked;
  int    n_period_ends;

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int chain_len();
    return clamp_to(shadow_cfg.reg_count, 1, bcm_pkg::MaxRegs) *
           clamp_to(shadow_cfg.reg_width, bcm_pkg::MinWidth, bcm_pkg::MaxWidth);
  endfunction

  function automatic void restart_scan();
    plane = 0;
    reps  = 0;
    slot  = 0;
  endfunction

  function automatic void clear_model();
    shadow_cfg  = bcm_pkg::CFG_RESET;
    refresh_due = 1'b0;
    for (int i = 0; i < bcm_pkg::StoreDepth; i++) begin
      duty_ram[i]  = '0;
      shown_ram[i] = '0;
    end
    restart_scan();
  endfunction

  function automatic void apply_reg(input logic [bcm_pkg::CfgIdxW-1:0] idx,
                                    input logic [bcm_pkg::CfgDataW-1:0] val);
    case (idx)
      bcm_pkg::CFG_REG_COUNT:     shadow_cfg.reg_count     = val[bcm_pkg::CountW-1:0];
      bcm_pkg::CFG_REG_WIDTH:     shadow_cfg.reg_width     = val[bcm_pkg::WidthW-1:0];
      bcm_pkg::CFG_BIT_DEPTH:     shadow_cfg.bit_depth     = val[bcm_pkg::DepthW-1:0];
      bcm_pkg::CFG_LATCH_POS:     shadow_cfg.latch_pos     = val[bcm_pkg::LatchW-1:0];
      bcm_pkg::CFG_REVERSE_ORDER: shadow_cfg.reverse_order = val[0];
      default:                    return;
    endcase
    restart_scan();
  endfunction

  // Update the stores or emit the next scan word for one accepted item.
  function automatic word_t scan_item(input logic op,
                                      input logic [bcm_pkg::AddrW-1:0] led,
                                      input logic [bcm_pkg::DutyW-1:0] duty);
    int count;
    int width;
    int depth;
    int lane_pos;
    int lpos;
    word_t w;
    count = clamp_to(shadow_cfg.reg_count, 1, bcm_pkg::MaxRegs);
    width = clamp_to(shadow_cfg.reg_width, bcm_pkg::MinWidth, bcm_pkg::MaxWidth);
    depth = clamp_to(shadow_cfg.bit_depth, bcm_pkg::MinDepth, bcm_pkg::MaxDepth);
    w = '0;
    if (op == bcm_pkg::OP_WRITE) begin
      if (int'(led) < count * width) begin
        duty_ram[led] = duty & bcm_pkg::DutyW'((1 << depth) - 1);
        refresh_due = 1'b1;
      end
      return w;
    end
    if (plane >= depth || slot >= width || reps >= (1 << plane)) restart_scan();
    lane_pos = shadow_cfg.reverse_order ? slot : width - 1 - slot;
    for (int r = 0; r < count; r++) begin
      w.data[r] = shown_ram[bcm_pkg::AddrW'(lane_pos + r * width)][plane];
    end
    lpos = (int'(shadow_cfg.latch_pos) > width - 1) ? width - 1 : int'(shadow_cfg.latch_pos);
    w.latch = (slot == lpos);
    w.last = (plane == depth - 1 && reps == (1 << plane) - 1 && slot == width - 1);
    // Advance position, then repeat, then bit plane; latch pending writes at the wrap
    slot++;
    if (slot >= width) begin
      slot = 0;
      reps++;
      if (reps >= (1 << plane)) begin
        reps = 0;
        plane++;
        if (plane >= depth) begin
          plane = 0;
          if (refresh_due) begin
            shown_ram = duty_ram;
            refresh_due = 1'b0;
          end
        end
      end
    end
    return w;
  endfunction

  task automatic send_item(input logic op, input logic [bcm_pkg::AddrW-1:0] led,
                           input logic [bcm_pkg::DutyW-1:0] duty, input logic typed,
                           input word_t want);
    word_t w;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.led_index  <= led;
    in_ch.duty_value <= duty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    w = scan_item(op, led, duty);
    if (op == bcm_pkg::OP_TICK) begin
      words_due.push_back(typed ? want : w);
      n_ticks++;
    end else begin
      n_writes++;
    end
  endtask

  // Hold off the input until every expected word has been seen
  task automatic wait_words_out();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    wait_words_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [bcm_pkg::CfgIdxW-1:0] idx,
                         input logic [bcm_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    n_reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
                 idle_cycles, words_due.size());
        $display("Regression FAIL");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (out_ch.period_end === 1'b1) n_period_ends++;
        if (words_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected word data %h latch %b end %b", $time,
                     out_ch.data_lines, out_ch.latch_line, out_ch.period_end);
        end else begin
          want_word = words_due.pop_front();
          if (out_ch.data_lines !== want_word.data || out_ch.latch_line !== want_word.latch ||
              out_ch.period_end !== want_word.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: word mismatch: expected data %h latch %b end %b, got %h %b %b",
                       $time, want_word.data, want_word.latch, want_word.last,
                       out_ch.data_lines, out_ch.latch_line, out_ch.period_end);
          end
        end
      end
    end
  end

  initial begin
    bit prev_cfg;
    int n;
    int span;
    int pick;
    logic [bcm_pkg::CfgDataW-1:0] cnt;
    logic [bcm_pkg::CfgDataW-1:0] wid;
    logic [bcm_pkg::CfgDataW-1:0] dep;
    logic [bcm_pkg::CfgDataW-1:0] lat;
    logic [bcm_pkg::CfgDataW-1:0] rev;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = bcm_pkg::OP_WRITE;
    in_ch.led_index = '0;
    in_ch.duty_value = '0;
    steady = 1'b0;
    errors = 0;
    n_ticks = 0;
    n_writes = 0;
    n_reg_writes = 0;
    n_checked = 0;
    n_period_ends = 0;
    clear_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // Give the store clearing pass time before touching the registers
    repeat (SETTLE_CYCLES) @(posedge clk);

    prev_cfg = 1'b1;
    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        if (!prev_cfg) quiesce();
        set_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
        prev_cfg = 1'b1;
      end else begin
        send_item(PLAN[i].op, PLAN[i].led, PLAN[i].duty, PLAN[i].typed, PLAN[i].want);
        prev_cfg = 1'b0;
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 5 || phase == 6);
      quiesce();
      if (phase == 0) begin
        cnt = 6'd1; wid = 6'd4; dep = 6'd4; lat = 6'd0; rev = 6'd0;
      end else if (phase == 1) begin
        cnt = 6'd8; wid = 6'd32; dep = 6'd12; lat = 6'd31; rev = 6'd1;
      end else begin
        // Keep periods short most of the time so the display update gets exercised
        cnt = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 8));
        pick = $urandom_range(0, 19);
        wid = (pick < 3) ? 6'($urandom) :
              (pick < 17) ? 6'($urandom_range(4, 5)) : 6'($urandom_range(6, 16));
        pick = $urandom_range(0, 19);
        dep = (pick < 3) ? 6'($urandom) : (pick < 15) ? 6'd4 : 6'd5;
        lat = 6'($urandom);
        rev = 6'($urandom);
      end
      set_reg(bcm_pkg::CFG_REG_COUNT, cnt);
      set_reg(bcm_pkg::CFG_REG_WIDTH, wid);
      set_reg(bcm_pkg::CFG_BIT_DEPTH, dep);
      set_reg(bcm_pkg::CFG_LATCH_POS, lat);
      set_reg(bcm_pkg::CFG_REVERSE_ORDER, rev);
      if ($urandom_range(0, 3) == 0) set_reg(3'(CFG_SPARE + $urandom_range(0, 2)), 6'($urandom));
      span = chain_len();
      n = $urandom_range(70, 125);
      for (int k = 0; k < n; k++) begin
        if (phase % 4 == 3 && k == n / 2) wait_words_out();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_item(bcm_pkg::OP_TICK, 8'($urandom), 12'($urandom), 1'b0, '0);
        end else if (pick < 96) begin
          send_item(bcm_pkg::OP_WRITE, 8'($urandom_range(0, span - 1)), 12'($urandom),
                    1'b0, '0);
        end else begin
          send_item(bcm_pkg::OP_WRITE, 8'($urandom), 12'($urandom), 1'b0, '0);
        end
      end
    end

    steady = 1'b0;
    wait_words_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += words_due.size();
    $display("Sent %0d ticks and %0d LED writes over %0d register writes and %0d phases",
             n_ticks, n_writes, n_reg_writes, PHASES);
    $display("Checked %0d words, %0d of them period ends; %0d mismatches",
             n_checked, n_period_ends, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== bcm_shift_register_led_driver.f =====
sv/bcm_pkg.sv
sv/bcm_if.sv
sv/bcm_ram.sv
sv/bcm_frame_ctr.sv
sv/bcm_lane_gather.sv
sv/bcm_shift_register_led_driver.sv
sim/bcm_shift_register_led_driver_test.sv
